[hw/rtl/tmvhi_pkg.sv]
// Shared types, constants and the multiply step table of the tetrahedron volume/heat integrator.
package tmvhi_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int TEMP_WIDTH_DEF  = 16;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 128;
	localparam int VOL_W  = 49;
	localparam int VACC_W = 63;
	localparam int E_W    = 64;
	localparam int STEP_W = 5;

	localparam logic [15:0] DENSITY_RST       = 16'd1000;
	localparam logic [15:0] SPECIFIC_HEAT_RST = 16'd1000;
	localparam logic [5:0]  ENERGY_SHIFT_RST  = 6'd0;

	localparam logic [STEP_W-1:0] STEP_FIRST_A = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_LAST_A  = STEP_W'(13);
	localparam logic [STEP_W-1:0] STEP_FIRST_B = STEP_W'(14);
	localparam logic [STEP_W-1:0] STEP_LAST_B  = STEP_W'(17);

	typedef enum logic [1:0] {
		CFG_DENSITY       = 2'd0,
		CFG_SPECIFIC_HEAT = 2'd1,
		CFG_ENERGY_SHIFT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		MS_NONE,
		MS_DENS_SH,
		MS_AY_BZ,
		MS_AZ_BY,
		MS_AZ_BX,
		MS_AX_BZ,
		MS_AX_BY,
		MS_AY_BX,
		MS_G_MAG,
		MS_CX_XLO,
		MS_CX_XHI,
		MS_CY_YLO,
		MS_CY_YHI,
		MS_CZ_ZLO,
		MS_CZ_ZHI,
		MS_V0_F0,
		MS_V0_F1,
		MS_V1_F0,
		MS_V1_F1
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_32,
		SH_64
	} acc_sh_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_G,
		DST_F,
		DST_XX,
		DST_XY,
		DST_XZ
	} dest_t;

	typedef struct packed {
		mul_sel_t sel;
		acc_op_t  op;
		acc_sh_t  sh;
		dest_t    dest;
	} mstep_t;

	typedef struct packed {
		logic       vtx_wr;
		logic [1:0] vtx_idx;
		logic       latch;
		mstep_t     mstep;
		logic       div_load;
		logic       div_step;
		logic       acc_neg;
		logic       sat;
		logic       out_load;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		S_IN,
		S_MUL_A,
		S_WAIT_A,
		S_DIV_LD,
		S_DIV,
		S_MUL_B,
		S_WAIT_B,
		S_NEG,
		S_SAT,
		S_OUT
	} state_t;

	// divide-by-six runs eight quotient bits per cycle over the |det| width
	function automatic int div_cycles(input int cw);
		return (3 * (cw + 1) + 7) / 8;
	endfunction

	function automatic mstep_t mul_step(input logic [STEP_W-1:0] idx);
		mstep_t s;
		s = '{sel: MS_NONE, op: ACC_NONE, sh: SH_0, dest: DST_NONE};
		case (idx)
			5'd0:  s = '{sel: MS_DENS_SH, op: ACC_LOAD, sh: SH_0,  dest: DST_G};
			5'd1:  s = '{sel: MS_AY_BZ,   op: ACC_LOAD, sh: SH_0,  dest: DST_NONE};
			5'd2:  s = '{sel: MS_AZ_BY,   op: ACC_SUB,  sh: SH_0,  dest: DST_XX};
			5'd3:  s = '{sel: MS_AZ_BX,   op: ACC_LOAD, sh: SH_0,  dest: DST_NONE};
			5'd4:  s = '{sel: MS_AX_BZ,   op: ACC_SUB,  sh: SH_0,  dest: DST_XY};
			5'd5:  s = '{sel: MS_AX_BY,   op: ACC_LOAD, sh: SH_0,  dest: DST_NONE};
			5'd6:  s = '{sel: MS_AY_BX,   op: ACC_SUB,  sh: SH_0,  dest: DST_XZ};
			5'd7:  s = '{sel: MS_G_MAG,   op: ACC_LOAD, sh: SH_0,  dest: DST_F};
			5'd8:  s = '{sel: MS_CX_XLO,  op: ACC_LOAD, sh: SH_0,  dest: DST_NONE};
			5'd9:  s = '{sel: MS_CX_XHI,  op: ACC_ADD,  sh: SH_32, dest: DST_NONE};
			5'd10: s = '{sel: MS_CY_YLO,  op: ACC_ADD,  sh: SH_0,  dest: DST_NONE};
			5'd11: s = '{sel: MS_CY_YHI,  op: ACC_ADD,  sh: SH_32, dest: DST_NONE};
			5'd12: s = '{sel: MS_CZ_ZLO,  op: ACC_ADD,  sh: SH_0,  dest: DST_NONE};
			5'd13: s = '{sel: MS_CZ_ZHI,  op: ACC_ADD,  sh: SH_32, dest: DST_NONE};
			5'd14: s = '{sel: MS_V0_F0,   op: ACC_LOAD, sh: SH_0,  dest: DST_NONE};
			5'd15: s = '{sel: MS_V0_F1,   op: ACC_ADD,  sh: SH_32, dest: DST_NONE};
			5'd16: s = '{sel: MS_V1_F0,   op: ACC_ADD,  sh: SH_32, dest: DST_NONE};
			5'd17: s = '{sel: MS_V1_F1,   op: ACC_ADD,  sh: SH_64, dest: DST_NONE};
			default: s = '{sel: MS_NONE, op: ACC_NONE, sh: SH_0, dest: DST_NONE};
		endcase
		return s;
	endfunction

endpackage

[hw/rtl/tetra_mesh_volume_heat_integrator.sv]
// Top level of the tetrahedron volume and heat-energy integrator.
//
// Input channel (in_valid/in_ready): one vertex per item, four items per
// tetrahedron. End flags count only on the fourth vertex; object_end also
// ends the material. Output channel (out_valid/out_ready): one result item
// per tetrahedron with its volume and energy and the running, saturating
// material and object totals; the done flags mark final totals, which are
// then cleared. Config channel (cfg_valid/cfg_ready, always ready): index 0
// density, 1 specific heat, 2 energy shift; write only while idle.
// The first three vertices are stored on arrival. After the fourth, the
// shared 33x33 multiplier runs 18 steps, with the divide-by-six unit
// between them. No vertex is taken during that computation.
// The result sits in an output register: vertices of the next tetrahedron
// are taken while it waits, and the block stalls only when a new result is
// ready before the old one was taken.
// Reset clears vertex count, totals and output valid, and restores the
// configuration to density 1000, specific heat 1000, shift 0.
module tetra_mesh_volume_heat_integrator import tmvhi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TEMP_WIDTH  = TEMP_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic signed [TEMP_WIDTH-1:0]  temperature,
	input  logic                          material_end,
	input  logic                          object_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [VOL_W-1:0]              tetra_volume,
	output logic signed [E_W-1:0]         tetra_energy,
	output logic [VACC_W-1:0]             material_volume,
	output logic signed [E_W-1:0]         material_energy,
	output logic [VACC_W-1:0]             object_volume,
	output logic signed [E_W-1:0]         object_energy,
	output logic                          material_done,
	output logic                          object_done
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	tmvhi_ctrl #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	tmvhi_dp #(
		.COORD_WIDTH(COORD_WIDTH),
		.TEMP_WIDTH (TEMP_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.temperature    (temperature),
		.material_end   (material_end),
		.object_end     (object_end),
		.cmd            (cmd),
		.tetra_volume   (tetra_volume),
		.tetra_energy   (tetra_energy),
		.material_volume(material_volume),
		.material_energy(material_energy),
		.object_volume  (object_volume),
		.object_energy  (object_energy),
		.material_done  (material_done),
		.object_done    (object_done)
	);

endmodule

[hw/rtl/tmvhi_ctrl.sv]
// Controller: vertex counting, step sequencing and output handshake.
module tmvhi_ctrl import tmvhi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	localparam int DIV_CYC = div_cycles(COORD_WIDTH);
	localparam logic [STEP_W-1:0] STEP_LAST_DIV = STEP_W'(DIV_CYC - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [1:0]        vcnt_q, vcnt_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IN;
			step_q      <= '0;
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			vcnt_q      <= vcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		vcnt_d   = vcnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.vtx_idx = vcnt_q;
		unique case (state_q)
			S_IN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (vcnt_q != 2'd3) begin
						cmd.vtx_wr = 1'b1;
						vcnt_d     = vcnt_q + 2'd1;
					end else begin
						cmd.latch = 1'b1;
						vcnt_d    = 2'd0;
						step_d    = STEP_FIRST_A;
						state_d   = S_MUL_A;
					end
				end
			end
			S_MUL_A: begin
				cmd.mstep = mul_step(step_q);
				if (step_q == STEP_LAST_A) begin
					state_d = S_WAIT_A;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_WAIT_A: begin
				state_d = S_DIV_LD;
			end
			S_DIV_LD: begin
				cmd.div_load = 1'b1;
				step_d       = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST_DIV) begin
					step_d  = STEP_FIRST_B;
					state_d = S_MUL_B;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_MUL_B: begin
				cmd.mstep = mul_step(step_q);
				if (step_q == STEP_LAST_B) begin
					state_d = S_WAIT_B;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_WAIT_B: begin
				state_d = S_NEG;
			end
			S_NEG: begin
				cmd.acc_neg = 1'b1;
				state_d     = S_SAT;
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IN;
				end
			end
			default: begin
				state_d = S_IN;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_load_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (vcnt_q == 2'd0))
		else $error("result loaded in the middle of a vertex group");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.mstep.op != ACC_NONE || cmd.sat) |-> !in_ready)
		else $error("input taken while datapath busy");

endmodule

[hw/rtl/tmvhi_dp.sv]
// Datapath: vertex store, shared multiplier and accumulator, divide-by-six, totals.
module tmvhi_dp import tmvhi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TEMP_WIDTH  = TEMP_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic signed [TEMP_WIDTH-1:0]  temperature,
	input  logic                          material_end,
	input  logic                          object_end,
	input  dp_cmd_t                       cmd,
	output logic [VOL_W-1:0]              tetra_volume,
	output logic signed [E_W-1:0]         tetra_energy,
	output logic [VACC_W-1:0]             material_volume,
	output logic signed [E_W-1:0]         material_energy,
	output logic [VACC_W-1:0]             object_volume,
	output logic signed [E_W-1:0]         object_energy,
	output logic                          material_done,
	output logic                          object_done
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int SW   = TEMP_WIDTH + 2;
	localparam int DIVW = 8 * div_cycles(COORD_WIDTH);

	localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
	localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

	function automatic logic signed [E_W-1:0] sat_add(
		input logic signed [E_W-1:0] a,
		input logic signed [E_W-1:0] b
	);
		logic signed [E_W-1:0] s;
		s = a + b;
		if (a[E_W-1] == b[E_W-1] && s[E_W-1] != a[E_W-1]) begin
			return a[E_W-1] ? E_MIN : E_MAX;
		end
		return s;
	endfunction

	// config
	logic [15:0] density_q, specific_heat_q;
	logic [5:0]  energy_shift_q;

	// vertex store
	logic signed [COORD_WIDTH-1:0] vx_q [3];
	logic signed [COORD_WIDTH-1:0] vy_q [3];
	logic signed [COORD_WIDTH-1:0] vz_q [3];
	logic signed [TEMP_WIDTH-1:0]  vt_q [3];

	// edge vectors and temperature sum of the current tetrahedron
	logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [SW-1:0] sumt_q;
	logic                 mend_q, oend_q;
	logic [SW-1:0]        mag;

	// intermediate products
	logic [31:0]        g_q;
	logic [63:0]        f_q;
	logic signed [63:0] crx_q, cry_q, crz_q;

	// multiplier and accumulator
	logic signed [MUL_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod, p_s1;
	mstep_t                   mop_s1;
	logic signed [ACC_W-1:0]  acc_q, acc_next, addend, p_ext;
	logic [ACC_W-1:0]         det_abs;

	// divider
	logic [DIVW-1:0] num_q, dn;
	logic [2:0]      rem_q, dr;
	logic [3:0]      dt;
	logic [63:0]     vol64;

	// energy finish
	logic [6:0]              shamt;
	logic signed [ACC_W-1:0] e_sh;
	logic signed [E_W-1:0]   e_sat;
	logic [VOL_W-1:0]        tv_q;
	logic signed [E_W-1:0]   te_q;

	// totals and output register
	logic [VACC_W-1:0]     mat_vol_q, obj_vol_q;
	logic signed [E_W-1:0] mat_energy_q, obj_energy_q;
	logic [63:0]           mv_sum, ov_sum;
	logic [VACC_W-1:0]     mv_new, ov_new;
	logic signed [E_W-1:0] me_new, oe_new;
	logic [VOL_W-1:0]      tvol_q;
	logic signed [E_W-1:0] tene_q;
	logic [VACC_W-1:0]     mvol_out_q, ovol_out_q;
	logic signed [E_W-1:0] mene_out_q, oene_out_q;
	logic                  mdone_q, odone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q       <= DENSITY_RST;
			specific_heat_q <= SPECIFIC_HEAT_RST;
			energy_shift_q  <= ENERGY_SHIFT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DENSITY:       density_q       <= cfg_data;
				CFG_SPECIFIC_HEAT: specific_heat_q <= cfg_data;
				CFG_ENERGY_SHIFT:  energy_shift_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vtx_wr) begin
			vx_q[cmd.vtx_idx] <= coord_x;
			vy_q[cmd.vtx_idx] <= coord_y;
			vz_q[cmd.vtx_idx] <= coord_z;
			vt_q[cmd.vtx_idx] <= temperature;
		end
		if (cmd.latch) begin
			ax_q   <= DW'(vx_q[1]) - DW'(vx_q[0]);
			ay_q   <= DW'(vy_q[1]) - DW'(vy_q[0]);
			az_q   <= DW'(vz_q[1]) - DW'(vz_q[0]);
			bx_q   <= DW'(vx_q[2]) - DW'(vx_q[0]);
			by_q   <= DW'(vy_q[2]) - DW'(vy_q[0]);
			bz_q   <= DW'(vz_q[2]) - DW'(vz_q[0]);
			cx_q   <= DW'(coord_x) - DW'(vx_q[0]);
			cy_q   <= DW'(coord_y) - DW'(vy_q[0]);
			cz_q   <= DW'(coord_z) - DW'(vz_q[0]);
			sumt_q <= SW'(vt_q[0]) + SW'(vt_q[1]) + SW'(vt_q[2]) + SW'(temperature);
			mend_q <= material_end;
			oend_q <= object_end;
		end
	end

	assign mag   = sumt_q[SW-1] ? SW'(-sumt_q) : sumt_q;
	assign vol64 = 64'(num_q);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.mstep.sel)
			MS_DENS_SH: begin ma = MUL_W'(density_q); mb = MUL_W'(specific_heat_q); end
			MS_AY_BZ:   begin ma = MUL_W'(ay_q); mb = MUL_W'(bz_q); end
			MS_AZ_BY:   begin ma = MUL_W'(az_q); mb = MUL_W'(by_q); end
			MS_AZ_BX:   begin ma = MUL_W'(az_q); mb = MUL_W'(bx_q); end
			MS_AX_BZ:   begin ma = MUL_W'(ax_q); mb = MUL_W'(bz_q); end
			MS_AX_BY:   begin ma = MUL_W'(ax_q); mb = MUL_W'(by_q); end
			MS_AY_BX:   begin ma = MUL_W'(ay_q); mb = MUL_W'(bx_q); end
			MS_G_MAG:   begin ma = MUL_W'(g_q); mb = MUL_W'(mag); end
			MS_CX_XLO:  begin ma = MUL_W'(cx_q); mb = MUL_W'(crx_q[31:0]); end
			MS_CX_XHI:  begin ma = MUL_W'(cx_q); mb = MUL_W'($signed(crx_q[63:32])); end
			MS_CY_YLO:  begin ma = MUL_W'(cy_q); mb = MUL_W'(cry_q[31:0]); end
			MS_CY_YHI:  begin ma = MUL_W'(cy_q); mb = MUL_W'($signed(cry_q[63:32])); end
			MS_CZ_ZLO:  begin ma = MUL_W'(cz_q); mb = MUL_W'(crz_q[31:0]); end
			MS_CZ_ZHI:  begin ma = MUL_W'(cz_q); mb = MUL_W'($signed(crz_q[63:32])); end
			MS_V0_F0:   begin ma = MUL_W'(vol64[31:0]); mb = MUL_W'(f_q[31:0]); end
			MS_V0_F1:   begin ma = MUL_W'(vol64[31:0]); mb = MUL_W'(f_q[63:32]); end
			MS_V1_F0:   begin ma = MUL_W'(vol64[63:32]); mb = MUL_W'(f_q[31:0]); end
			MS_V1_F1:   begin ma = MUL_W'(vol64[63:32]); mb = MUL_W'(f_q[63:32]); end
			default:    begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk) begin
		p_s1 <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mop_s1 <= '{sel: MS_NONE, op: ACC_NONE, sh: SH_0, dest: DST_NONE};
		end else begin
			mop_s1 <= cmd.mstep;
		end
	end

	assign p_ext = ACC_W'(p_s1);

	always_comb begin
		unique case (mop_s1.sh)
			SH_0:    addend = p_ext;
			SH_32:   addend = p_ext <<< 32;
			SH_64:   addend = p_ext <<< 64;
			default: addend = p_ext;
		endcase
		unique case (mop_s1.op)
			ACC_LOAD: acc_next = addend;
			ACC_ADD:  acc_next = acc_q + addend;
			ACC_SUB:  acc_next = acc_q - addend;
			default:  acc_next = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mop_s1.op != ACC_NONE) begin
			acc_q <= acc_next;
			unique case (mop_s1.dest)
				DST_G:   g_q   <= acc_next[31:0];
				DST_F:   f_q   <= acc_next[63:0];
				DST_XX:  crx_q <= acc_next[63:0];
				DST_XY:  cry_q <= acc_next[63:0];
				DST_XZ:  crz_q <= acc_next[63:0];
				default: ;
			endcase
		end else if (cmd.acc_neg && sumt_q[SW-1]) begin
			acc_q <= -acc_q;
		end
	end

	// |det| / 6, restoring, eight quotient bits a cycle
	assign det_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	always_comb begin
		dn = num_q;
		dr = rem_q;
		dt = '0;
		for (int i = 0; i < 8; i++) begin
			dt = {dr, dn[DIVW-1]};
			dn = {dn[DIVW-2:0], 1'b0};
			if (dt >= 4'd6) begin
				dr    = 3'(dt - 4'd6);
				dn[0] = 1'b1;
			end else begin
				dr = dt[2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= det_abs[DIVW-1:0];
		end else if (cmd.div_step) begin
			num_q <= dn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.div_load) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= dr;
		end
	end

	assign shamt = 7'(energy_shift_q) + 7'd2;
	assign e_sh  = acc_q >>> shamt;

	always_comb begin
		if ((&e_sh[ACC_W-1:E_W-1]) || !(|e_sh[ACC_W-1:E_W-1])) begin
			e_sat = e_sh[E_W-1:0];
		end else begin
			e_sat = e_sh[ACC_W-1] ? E_MIN : E_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sat) begin
			te_q <= e_sat;
			tv_q <= (|vol64[63:VOL_W]) ? {VOL_W{1'b1}} : vol64[VOL_W-1:0];
		end
	end

	assign mv_sum = {1'b0, mat_vol_q} + 64'(tv_q);
	assign ov_sum = {1'b0, obj_vol_q} + 64'(tv_q);
	assign mv_new = mv_sum[63] ? {VACC_W{1'b1}} : mv_sum[VACC_W-1:0];
	assign ov_new = ov_sum[63] ? {VACC_W{1'b1}} : ov_sum[VACC_W-1:0];
	assign me_new = sat_add(mat_energy_q, te_q);
	assign oe_new = sat_add(obj_energy_q, te_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_vol_q    <= '0;
			mat_energy_q <= '0;
			obj_vol_q    <= '0;
			obj_energy_q <= '0;
		end else if (cmd.out_load) begin
			mat_vol_q    <= (mend_q || oend_q) ? '0 : mv_new;
			mat_energy_q <= (mend_q || oend_q) ? '0 : me_new;
			obj_vol_q    <= oend_q ? '0 : ov_new;
			obj_energy_q <= oend_q ? '0 : oe_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tvol_q     <= tv_q;
			tene_q     <= te_q;
			mvol_out_q <= mv_new;
			mene_out_q <= me_new;
			ovol_out_q <= ov_new;
			oene_out_q <= oe_new;
			mdone_q    <= mend_q || oend_q;
			odone_q    <= oend_q;
		end
	end

	assign tetra_volume    = tvol_q;
	assign tetra_energy    = tene_q;
	assign material_volume = mvol_out_q;
	assign material_energy = mene_out_q;
	assign object_volume   = ovol_out_q;
	assign object_energy   = oene_out_q;
	assign material_done   = mdone_q;
	assign object_done     = odone_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd5)
		else $error("divider remainder out of range");

	a_obj_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && oend_q) |=> (obj_vol_q == '0 && obj_energy_q == '0))
		else $error("object totals not cleared at object end");

	a_mat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (mend_q || oend_q)) |=> (mat_vol_q == '0 && mat_energy_q == '0))
		else $error("material totals not cleared at material end");

endmodule

[dv/tb_tetra_mesh_volume_heat_integrator.sv]
// Self-checking testbench for the tetrahedron volume and heat-energy integrator.
module tb_tetra_mesh_volume_heat_integrator;
	timeunit 1ns;
	timeprecision 1ps;

	import tmvhi_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int TW = TEMP_WIDTH_DEF;
	localparam int CMIN = -(1 << (CW - 1));
	localparam int CMAX = (1 << (CW - 1)) - 1;
	localparam int TMIN = -(1 << (TW - 1));
	localparam int TMAX = (1 << (TW - 1)) - 1;
	localparam int IDLE_GAP = 40;
	localparam int END_GAP = 60;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 6;
	localparam int TETRAS_PER_PHASE = 46;
	localparam logic signed [127:0] ENERGY_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] ENERGY_LO = -128'sh8000_0000_0000_0000;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [TW-1:0] t;
	} vertex_t;

	typedef vertex_t tetra_t [4];

	typedef struct {
		logic [VOL_W-1:0]      volume;
		logic signed [E_W-1:0] energy;
		logic [VACC_W-1:0]     mat_volume;
		logic signed [E_W-1:0] mat_energy;
		logic [VACC_W-1:0]     obj_volume;
		logic signed [E_W-1:0] obj_energy;
		logic                  mat_done;
		logic                  obj_done;
	} tetra_result_t;

	class heat_scoreboard;
		logic [15:0]           density;
		logic [15:0]           spec_heat;
		logic [5:0]            shift;
		vertex_t               corner [3];
		int unsigned           held;
		logic [VACC_W-1:0]     mat_volume;
		logic [VACC_W-1:0]     obj_volume;
		logic signed [E_W-1:0] mat_energy;
		logic signed [E_W-1:0] obj_energy;
		tetra_result_t         pending_q [$];
		int unsigned           mismatches;

		function new();
			density = DENSITY_RST;
			spec_heat = SPECIFIC_HEAT_RST;
			shift = ENERGY_SHIFT_RST;
			held = 0;
			mat_volume = '0;
			obj_volume = '0;
			mat_energy = '0;
			obj_energy = '0;
			mismatches = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [15:0] data);
			case (idx)
				CFG_DENSITY: density = data;
				CFG_SPECIFIC_HEAT: spec_heat = data;
				CFG_ENERGY_SHIFT: shift = data[5:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		function logic [VACC_W-1:0] add_volume(logic [VACC_W-1:0] acc, logic [VOL_W-1:0] v);
			logic [VACC_W:0] s;
			s = acc + v;
			return s[VACC_W] ? '1 : s[VACC_W-1:0];
		endfunction

		function logic signed [E_W-1:0] add_energy(logic signed [E_W-1:0] a,
				logic signed [E_W-1:0] b);
			logic signed [E_W-1:0] s;
			s = a + b;
			if (a[E_W-1] == b[E_W-1] && s[E_W-1] != a[E_W-1])
				s = a[E_W-1] ? {1'b1, {(E_W-1){1'b0}}} : {1'b0, {(E_W-1){1'b1}}};
			return s;
		endfunction

		function void note_vertex(vertex_t v, logic mend, logic oend);
			longint ax, ay, az, bx, by, bz, cx, cy, cz, sum_t, mag;
			logic signed [127:0] det, vol, heat;
			tetra_result_t r;
			if (held < 3) begin
				corner[held] = v;
				held++;
				return;
			end
			held = 0;
			ax = longint'(corner[1].x) - longint'(corner[0].x);
			ay = longint'(corner[1].y) - longint'(corner[0].y);
			az = longint'(corner[1].z) - longint'(corner[0].z);
			bx = longint'(corner[2].x) - longint'(corner[0].x);
			by = longint'(corner[2].y) - longint'(corner[0].y);
			bz = longint'(corner[2].z) - longint'(corner[0].z);
			cx = longint'(v.x) - longint'(corner[0].x);
			cy = longint'(v.y) - longint'(corner[0].y);
			cz = longint'(v.z) - longint'(corner[0].z);
			det = cx * (ay * bz - az * by) + cy * (az * bx - ax * bz) + cz * (ax * by - ay * bx);
			if (det < 0)
				det = -det;
			vol = det / 6;
			r.volume = (vol[127:VOL_W] != '0) ? '1 : vol[VOL_W-1:0];

			// energy uses the unsaturated volume
			sum_t = longint'(corner[0].t) + longint'(corner[1].t) + longint'(corner[2].t)
				+ longint'(v.t);
			mag = (sum_t < 0) ? -sum_t : sum_t;
			heat = vol * mag * $signed({1'b0, density}) * $signed({1'b0, spec_heat});
			if (sum_t < 0)
				heat = -heat;
			heat = heat >>> (shift + 2);
			if (heat > ENERGY_HI)
				r.energy = ENERGY_HI[E_W-1:0];
			else if (heat < ENERGY_LO)
				r.energy = ENERGY_LO[E_W-1:0];
			else
				r.energy = heat[E_W-1:0];

			mat_volume = add_volume(mat_volume, r.volume);
			obj_volume = add_volume(obj_volume, r.volume);
			mat_energy = add_energy(mat_energy, r.energy);
			obj_energy = add_energy(obj_energy, r.energy);
			r.mat_volume = mat_volume;
			r.mat_energy = mat_energy;
			r.obj_volume = obj_volume;
			r.obj_energy = obj_energy;
			r.mat_done = mend | oend;
			r.obj_done = oend;
			if (mend | oend) begin
				mat_volume = '0;
				mat_energy = '0;
			end
			if (oend) begin
				obj_volume = '0;
				obj_energy = '0;
			end
			pending_q.push_back(r);
		endfunction

		function void compare(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				if (mismatches < 10)
					$display("%s: expected %h, got %h", what, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(tetra_result_t got);
			tetra_result_t want;
			if (pending_q.size() == 0) begin
				if (mismatches < 10)
					$display("result item with nothing pending, volume %h", got.volume);
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			compare("tetra_volume", want.volume, got.volume);
			compare("tetra_energy", want.energy, got.energy);
			compare("material_volume", want.mat_volume, got.mat_volume);
			compare("material_energy", want.mat_energy, got.mat_energy);
			compare("object_volume", want.obj_volume, got.obj_volume);
			compare("object_energy", want.obj_energy, got.obj_energy);
			compare("material_done", want.mat_done, got.mat_done);
			compare("object_done", want.obj_done, got.obj_done);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [15:0]           cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [CW-1:0]  coord_x = '0;
	logic signed [CW-1:0]  coord_y = '0;
	logic signed [CW-1:0]  coord_z = '0;
	logic signed [TW-1:0]  temperature = '0;
	logic                  material_end = 1'b0;
	logic                  object_end = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [VOL_W-1:0]      tetra_volume;
	logic signed [E_W-1:0] tetra_energy;
	logic [VACC_W-1:0]     material_volume;
	logic signed [E_W-1:0] material_energy;
	logic [VACC_W-1:0]     object_volume;
	logic signed [E_W-1:0] object_energy;
	logic                  material_done;
	logic                  object_done;

	heat_scoreboard sb = new();
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int unsigned idle_cycles = 0;

	tetra_mesh_volume_heat_integrator #(
		.COORD_WIDTH(CW),
		.TEMP_WIDTH(TW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.temperature(temperature),
		.material_end(material_end),
		.object_end(object_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tetra_volume(tetra_volume),
		.tetra_energy(tetra_energy),
		.material_volume(material_volume),
		.material_energy(material_energy),
		.object_volume(object_volume),
		.object_energy(object_energy),
		.material_done(material_done),
		.object_done(object_done)
	);

	always #10 clk = ~clk;

	// receiver: always ready, coin flip, rare ready, or long periodic stalls
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 160);
		end else
			rx_left <= rx_left - 1;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (rx_left % 32 == 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(tetra_result_t'{tetra_volume, tetra_energy, material_volume,
				material_energy, object_volume, object_energy, material_done, object_done});

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tetra_mesh_volume_heat_integrator: mismatch");
			$finish;
		end
	end

	function automatic vertex_t vtx(int x, int y, int z, int t);
		vertex_t v;
		v.x = CW'(x);
		v.y = CW'(y);
		v.z = CW'(z);
		v.t = TW'(t);
		return v;
	endfunction

	function automatic int jitter(int base, int span);
		return base + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_vertex(vertex_t v, logic mend, logic oend);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		coord_x <= v.x;
		coord_y <= v.y;
		coord_z <= v.z;
		temperature <= v.t;
		material_end <= mend;
		object_end <= oend;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_vertex(v, mend, oend);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic send_tetra(tetra_t q, logic [5:0] early, logic mend, logic oend,
			bit pause_mid = 1'b0);
		for (int i = 0; i < 3; i++) begin
			send_vertex(q[i], early[2*i], early[2*i+1]);
			if (pause_mid && i == 1)
				wait_drained();
		end
		send_vertex(q[3], mend, oend);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly mesh-like tetrahedra around a random base, some wild, a few flat
	task automatic random_tetra(bit pause_mid);
		tetra_t q;
		vertex_t base;
		int kind, span, tspan;
		kind = $urandom_range(0, 19);
		span = 1 << $urandom_range(0, 14);
		tspan = 1 << $urandom_range(0, 15);
		base = vtx($urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < 4; i++) begin
			if (kind < 6)
				q[i] = vtx($urandom, $urandom, $urandom, $urandom);
			else
				q[i] = vtx(jitter(base.x, span), jitter(base.y, span), jitter(base.z, span),
					jitter(base.t, tspan));
		end
		if (kind >= 18) begin
			q[3].x = q[1].x;
			q[3].y = q[1].y;
			q[3].z = q[1].z;
		end
		send_tetra(q, 6'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
			pause_mid);
	endtask

	initial begin
		tetra_t q;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest volume, hot: energy saturates, then the running totals do
		q = '{vtx(CMIN, CMIN, CMIN, TMAX), vtx(CMAX, CMIN, CMIN, TMAX),
			vtx(CMIN, CMAX, CMIN, TMAX), vtx(CMIN, CMIN, CMAX, TMAX)};
		send_tetra(q, 6'b111111, 1'b0, 1'b0);
		send_tetra(q, 6'b010101, 1'b0, 1'b0);
		// mirrored winding, coldest
		q = '{vtx(CMIN, CMIN, CMIN, TMIN), vtx(CMIN, CMAX, CMIN, TMIN),
			vtx(CMAX, CMIN, CMIN, TMIN), vtx(CMIN, CMIN, CMAX, TMIN)};
		send_tetra(q, 6'b101010, 1'b1, 1'b0);
		// flat, object end without material end
		q = '{vtx(0, 0, 0, 64), vtx(0, 0, 0, -64), vtx(0, 0, 0, TMAX), vtx(0, 0, 0, TMIN)};
		send_tetra(q, 6'b000000, 1'b0, 1'b1);
		q = '{vtx(0, 0, 0, 1280), vtx(1024, 0, 0, 1280), vtx(0, 1024, 0, 1280),
			vtx(0, 0, 1024, 1280)};
		send_tetra(q, 6'b000000, 1'b1, 1'b1);
		q = '{vtx(-5, -7, -9, -100), vtx(-300, -7, -9, -3200), vtx(-5, -900, -9, -6400),
			vtx(-5, -7, -2000, -50)};
		send_tetra(q, 6'b000000, 1'b0, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					write_reg(CFG_DENSITY, 16'hFFFF);
					write_reg(CFG_SPECIFIC_HEAT, 16'hFFFF);
					write_reg(CFG_ENERGY_SHIFT, 16'd0);
				end
				1: begin
					write_reg(CFG_DENSITY, 16'd0);
					write_reg(CFG_SPECIFIC_HEAT, 16'($urandom));
					write_reg(CFG_ENERGY_SHIFT, {10'($urandom), 6'd63});
				end
				2: begin
					write_reg(CFG_DENSITY, 16'($urandom));
					write_reg(CFG_SPECIFIC_HEAT, 16'($urandom));
					write_reg(CFG_ENERGY_SHIFT, 16'($urandom_range(0, 24)));
				end
				3: begin
					write_reg(CFG_DENSITY, 16'd1);
					write_reg(CFG_SPECIFIC_HEAT, 16'd1);
					write_reg(CFG_ENERGY_SHIFT, 16'd0);
				end
				4: begin
					write_reg(CFG_DENSITY, 16'($urandom));
					write_reg(CFG_SPECIFIC_HEAT, 16'($urandom));
					write_reg(CFG_ENERGY_SHIFT, 16'($urandom));
				end
				default: begin
					write_reg(CFG_DENSITY, 16'hFFFF);
					write_reg(CFG_SPECIFIC_HEAT, 16'hFFFF);
					write_reg(CFG_ENERGY_SHIFT, 16'd63);
				end
			endcase
			for (int n = 0; n < TETRAS_PER_PHASE; n++)
				random_tetra(p == 2 && n == 20);
			settle();
		end

		repeat (END_GAP) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tetra_mesh_volume_heat_integrator: match");
		else
			$display("tetra_mesh_volume_heat_integrator: mismatch");
		$finish;
	end

endmodule
